// ===== design/kst_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kst_pkg
// shared widths, command codes and entry types for the keyed slot table
// ---------------------------------------------------------------------------
package kst_pkg;

    localparam int SLOTS_DEF = 64;

    localparam int CMD_W  = 2;
    localparam int ID_W   = 31;
    localparam int DAY_W  = 5;
    localparam int MON_W  = 4;
    localparam int YEAR_W = 14;
    localparam int IDX_W  = 6;
    localparam int CNT_W  = 7;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COUNT  = 2'd2;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic              used;
        logic [ID_W-1:0]   item_id;
        logic [DAY_W-1:0]  day;
        logic [MON_W-1:0]  month;
        logic [YEAR_W-1:0] year;
    } t_entry;

    typedef struct packed {
        logic free;
        logic id_hit;
        logic full_hit;
    } t_cmp;

endpackage

// ===== design/keyed_slot_table.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// keyed_slot_table
// slot table with insert, remove-matching and count-by-id, one slot a cycle
// ---------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------
//  command  | in        | i_valid / o_stall  | i_cmd i_item_id i_day i_month i_year
//  result   | out       | o_valid / i_stall  | o_ok o_slot_index o_match_count
//
//  a command scans slots from index 0 through the single read port, one slot
//  per cycle; insert and remove stop at the first hit, count reads every slot;
//  an unknown command skips the scan; no new command is taken until the last
//  result is loaded into the output register
//  after reset a clearing pass writes every slot free; o_stall stays high
//  meanwhile
//  a new item is taken while a result still waits in the output register;
//  the next result waits for that register to empty
// ---------------------------------------------------------------------------
module keyed_slot_table
    import kst_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [ID_W-1:0]   i_item_id,
    input  logic [DAY_W-1:0]  i_day,
    input  logic [MON_W-1:0]  i_month,
    input  logic [YEAR_W-1:0] i_year,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_ok,
    output logic [IDX_W-1:0]  o_slot_index,
    output logic [CNT_W-1:0]  o_match_count
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_RESULT = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_addr, n_addr;
    logic             r_pend, n_pend;
    logic [IW-1:0]    r_pidx;
    logic [CMD_W-1:0] r_cmd;
    t_entry           r_key;
    logic             r_ok, n_ok;
    logic [IW-1:0]    r_hidx, n_hidx;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_vld, n_out_vld;
    logic             r_out_ok;
    logic [IDX_W-1:0] r_out_idx;
    logic [CNT_W-1:0] r_out_cnt;

    logic          w_accept;
    logic          w_load_out;
    logic          w_we;
    logic [IW-1:0] w_waddr;
    t_entry        w_wdata;
    logic          w_re;
    t_entry        w_rdata;
    t_cmp          w_cmp;

    kst_mem #(
        .SLOTS (SLOTS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_addr[IW-1:0]),
        .o_rdata (w_rdata)
    );

    kst_cmp u_cmp (
        .i_entry (w_rdata),
        .i_key   (r_key),
        .o_res   (w_cmp)
    );

    assign w_accept = i_valid && (r_state == ST_IDLE);

    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_ok       = r_ok;
        n_hidx     = r_hidx;
        n_cnt      = r_cnt;
        n_out_vld  = r_out_vld && i_stall;
        w_load_out = 1'b0;
        w_we       = 1'b0;
        w_waddr    = r_pidx;
        w_wdata    = r_key;
        w_re       = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_addr[IW-1:0];
                w_wdata = '0;
                n_addr  = r_addr + CW'(1);
                if (r_addr == CW'(SLOTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_addr = '0;
                    n_ok   = 1'b0;
                    n_hidx = '0;
                    n_cnt  = '0;
                    if (i_cmd == CMD_INSERT || i_cmd == CMD_REMOVE || i_cmd == CMD_COUNT) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_RESULT;
                    end
                end
            end
            ST_SCAN: begin
                w_re = (r_addr != CW'(SLOTS));
                if (w_re) begin
                    n_addr = r_addr + CW'(1);
                end
                // r_pend: read data for slot r_pidx is on w_rdata this cycle
                if (r_pend) begin
                    case (r_cmd)
                        CMD_INSERT: begin
                            if (w_cmp.free) begin
                                w_we    = 1'b1;
                                n_ok    = 1'b1;
                                n_hidx  = r_pidx;
                                n_state = ST_RESULT;
                            end
                        end
                        CMD_REMOVE: begin
                            if (w_cmp.full_hit) begin
                                w_we         = 1'b1;
                                w_wdata      = w_rdata;
                                w_wdata.used = 1'b0;
                                n_ok         = 1'b1;
                                n_hidx       = r_pidx;
                                n_state      = ST_RESULT;
                            end
                        end
                        CMD_COUNT: begin
                            if (w_cmp.id_hit && r_cnt != COUNT_MAX) begin
                                n_cnt = r_cnt + CNT_W'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (n_state == ST_SCAN && r_pidx == IW'(SLOTS - 1)) begin
                        n_state = ST_RESULT;
                    end
                end
            end
            ST_RESULT: begin
                if (!r_out_vld || !i_stall) begin
                    w_load_out = 1'b1;
                    n_out_vld  = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // reads issued in the cycle we leave the scan are dropped
        n_pend = w_re && (n_state == ST_SCAN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_addr    <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= r_addr[IW-1:0];
        r_ok   <= n_ok;
        r_hidx <= n_hidx;
        r_cnt  <= n_cnt;
        if (w_accept) begin
            r_cmd         <= i_cmd;
            r_key.used    <= 1'b1;
            r_key.item_id <= i_item_id;
            r_key.day     <= i_day;
            r_key.month   <= i_month;
            r_key.year    <= i_year;
        end
        if (w_load_out) begin
            r_out_ok  <= r_ok;
            r_out_idx <= IDX_W'(r_hidx);
            r_out_cnt <= r_cnt;
        end
    end

    assign o_stall       = (r_state != ST_IDLE);
    assign o_valid       = r_out_vld;
    assign o_ok          = r_out_ok;
    assign o_slot_index  = r_out_idx;
    assign o_match_count = r_out_cnt;

    // reset always starts the clearing pass
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> o_stall)
        else $error("block not busy clearing after reset");

    a_pend_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == ST_SCAN))
        else $error("slot read pending outside scan");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_RESULT) |-> !w_we)
        else $error("slot written while no command active");

    a_result_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_ok && o_match_count != '0) && (o_ok || o_slot_index == '0))
        else $error("result fields inconsistent");

endmodule

// ===== design/kst_mem.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kst_mem
// slot storage: one write port, one read port with registered read data
// ---------------------------------------------------------------------------
module kst_mem
    import kst_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [IW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic          i_re,
    input  logic [IW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [SLOTS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/kst_cmp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kst_cmp
// shared compare unit: checks one stored slot against the item key
// ---------------------------------------------------------------------------
module kst_cmp
    import kst_pkg::*;
(
    input  t_entry i_entry,
    input  t_entry i_key,
    output t_cmp   o_res
);

    logic w_id_eq;
    logic w_date_eq;

    assign w_id_eq   = (i_entry.item_id == i_key.item_id);
    assign w_date_eq = (i_entry.day == i_key.day) && (i_entry.month == i_key.month)
                       && (i_entry.year == i_key.year);

    // free slots never match, whatever they hold
    assign o_res.free     = !i_entry.used;
    assign o_res.id_hit   = i_entry.used && w_id_eq;
    assign o_res.full_hit = i_entry.used && w_id_eq && w_date_eq;

endmodule
